FILE: rtl/pgas_address_node_router_macros.svh
// Assertion macros shared by the address node router checker
`ifndef PGAS_ADDRESS_NODE_ROUTER_MACROS_SVH
`define PGAS_ADDRESS_NODE_ROUTER_MACROS_SVH

// Same-cycle implication, reset masked
`define PNR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pnr: same-cycle check failed");

// Next-cycle implication, reset masked
`define PNR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pnr: next-cycle check failed");

`endif

FILE: rtl/pnr_pkg.sv
// Shared constants, payload types and control structs of the address node router
`timescale 1ns / 1ps
package pnr_pkg;

   localparam int NODE_BITS = 16;
   localparam int ADDR_W    = 64;
   localparam int QUOT_BITS = NODE_BITS + 1;
   localparam int DIV_CNT_W = $clog2(ADDR_W + 1);

   localparam logic [DIV_CNT_W-1:0] SHARE_STEPS = DIV_CNT_W'(ADDR_W);
   localparam logic [DIV_CNT_W-1:0] NODE_STEPS  = DIV_CNT_W'(QUOT_BITS);

   localparam logic [3:0] XFER_CAP = 4'd8;

   // CSR indexes
   localparam logic [1:0] CSR_WINDOW_BASE = 2'd0;
   localparam logic [1:0] CSR_WINDOW_SIZE = 2'd1;
   localparam logic [1:0] CSR_LOCAL_NODE  = 2'd2;
   localparam logic [1:0] CSR_NODE_COUNT  = 2'd3;

   // Outcome codes
   localparam logic [2:0] OUT_RANGE        = 3'd0;
   localparam logic [2:0] OUT_UNROUTABLE   = 3'd1;
   localparam logic [2:0] OUT_LOCAL        = 3'd2;
   localparam logic [2:0] OUT_REMOTE_LOAD  = 3'd3;
   localparam logic [2:0] OUT_REMOTE_STORE = 3'd4;

   typedef struct packed {
      logic                     cmd;
      logic                     base_present;
      logic [ADDR_W-1:0]        base_value;
      logic                     index_present;
      logic [ADDR_W-1:0]        index_value;
      logic [3:0]               scale_factor;
      logic signed [ADDR_W-1:0] displacement;
      logic [4:0]               access_bytes;
      logic [ADDR_W-1:0]        store_value;
   } pnr_req_type;

   typedef struct packed {
      logic [2:0]           outcome;
      logic [NODE_BITS-1:0] target_node;
      logic [ADDR_W-1:0]    effective_address;
      logic [3:0]           transfer_bytes;
      logic [ADDR_W-1:0]    write_data;
      logic [ADDR_W-1:0]    local_total;
      logic [ADDR_W-1:0]    remote_load_total;
      logic [ADDR_W-1:0]    remote_store_total;
   } pnr_rsp_type;

   typedef struct packed {
      logic [1:0]        index;
      logic [ADDR_W-1:0] data;
   } pnr_csr_type;

   typedef struct packed {
      logic load_req;
      logic add_stage1;
      logic add_stage2;
      logic offset_calc;
      logic range_check;
      logic div_share;
      logic div_node;
      logic share_capture;
      logic finish;
   } pnr_cmd_type;

   typedef struct packed {
      logic routable;
      logic div_busy;
      logic out_free;
      logic cfg_touch;
   } pnr_sts_type;

endpackage

FILE: rtl/pnr_channels.sv
// Valid/ready channel interfaces: request, response and CSR write
`timescale 1ns / 1ps
interface pnr_req_if;
   import pnr_pkg::*;
   logic        valid;
   logic        ready;
   pnr_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pnr_rsp_if;
   import pnr_pkg::*;
   logic        valid;
   logic        ready;
   pnr_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pnr_csr_if;
   import pnr_pkg::*;
   logic        valid;
   logic        ready;
   pnr_csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/pnr_div.sv
// Iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module pnr_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pnr_pkg::ADDR_W-1:0]       rem_init,
   input  logic [pnr_pkg::ADDR_W-1:0]       dividend,
   input  logic [pnr_pkg::ADDR_W-1:0]       divisor,
   input  logic [pnr_pkg::DIV_CNT_W-1:0]    steps,
   output logic                             busy,
   output logic [pnr_pkg::ADDR_W-1:0]       quotient
);
   import pnr_pkg::*;

   logic [ADDR_W-1:0]    rem_ff;
   logic [ADDR_W-1:0]    dvd_ff;
   logic [ADDR_W-1:0]    dsr_ff;
   logic [ADDR_W-1:0]    quot_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   logic [ADDR_W:0] trial;
   logic [ADDR_W:0] diff;
   logic            ge;

   // partial remainder stays below the divisor, so the difference fits ADDR_W bits
   assign trial = {rem_ff, dvd_ff[ADDR_W-1]};
   assign ge    = trial >= {1'b0, dsr_ff};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= steps;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= rem_init;
         dvd_ff  <= dividend;
         dsr_ff  <= divisor;
         quot_ff <= '0;
      end else if (cnt_ff != '0) begin
         rem_ff  <= ge ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
         dvd_ff  <= {dvd_ff[ADDR_W-2:0], 1'b0};
         quot_ff <= {quot_ff[ADDR_W-2:0], ge};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quot_ff;

endmodule

FILE: rtl/pnr_ctrl.sv
// Sequencing state machine of the address node router
`timescale 1ns / 1ps
module pnr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pnr_pkg::pnr_sts_type sts,
   output pnr_pkg::pnr_cmd_type cmd
);
   import pnr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SHARE = 3'd1;
   localparam logic [2:0] S_ADD1  = 3'd2;
   localparam logic [2:0] S_ADD2  = 3'd3;
   localparam logic [2:0] S_OFFS  = 3'd4;
   localparam logic [2:0] S_RANGE = 3'd5;
   localparam logic [2:0] S_DIV   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       dirty_ff, dirty_in;

   // share is stale after a write to window size or node count
   assign req_ready = (state_ff == S_IDLE) && !dirty_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            priority if (dirty_ff) begin
               cmd.div_share = 1'b1;
               state_in      = S_SHARE;
            end else if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_ADD1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SHARE: begin
            if (!sts.div_busy) begin
               cmd.share_capture = 1'b1;
               state_in          = S_IDLE;
            end
         end
         S_ADD1: begin
            cmd.add_stage1 = 1'b1;
            state_in       = S_ADD2;
         end
         S_ADD2: begin
            cmd.add_stage2 = 1'b1;
            state_in       = S_OFFS;
         end
         S_OFFS: begin
            cmd.offset_calc = 1'b1;
            state_in        = S_RANGE;
         end
         S_RANGE: begin
            cmd.range_check = 1'b1;
            if (sts.routable) begin
               cmd.div_node = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
   end

   assign dirty_in = sts.cfg_touch || (dirty_ff && !cmd.div_share);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dirty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
      end
   end

endmodule

FILE: rtl/pnr_datapath.sv
// Address arithmetic, window check, node selection, counters and response register
`timescale 1ns / 1ps
module pnr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pnr_pkg::pnr_cmd_type cmd,
   output pnr_pkg::pnr_sts_type sts,
   input  pnr_pkg::pnr_req_type req_payload,
   input  logic                 csr_valid,
   input  pnr_pkg::pnr_csr_type csr_payload,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output pnr_pkg::pnr_rsp_type rsp_payload
);
   import pnr_pkg::*;

   pnr_req_type          req_ff;
   logic [ADDR_W-1:0]    sum_ff;
   logic [ADDR_W-1:0]    prod_ff;
   logic [ADDR_W-1:0]    ea_ff;
   logic [ADDR_W-1:0]    offset_ff;
   logic                 below_ff;
   logic                 in_win_ff;
   logic                 routable_ff;
   logic [ADDR_W-1:0]    share_ff;
   logic                 share_ok_ff;

   logic [ADDR_W-1:0]    wbase_ff;
   logic [ADDR_W-1:0]    wsize_ff;
   logic [NODE_BITS-1:0] local_node_ff;
   logic [NODE_BITS-1:0] node_count_ff;

   logic [ADDR_W-1:0]    local_cnt_ff, local_cnt_in;
   logic [ADDR_W-1:0]    rload_cnt_ff, rload_cnt_in;
   logic [ADDR_W-1:0]    rstore_cnt_ff, rstore_cnt_in;

   logic                 rsp_valid_ff;
   pnr_rsp_type          rsp_ff;

   // divider hookup
   logic                 div_start;
   logic [ADDR_W-1:0]    div_rem_init;
   logic [ADDR_W-1:0]    div_dividend;
   logic [ADDR_W-1:0]    div_divisor;
   logic [DIV_CNT_W-1:0] div_steps;
   logic                 div_busy;
   logic [ADDR_W-1:0]    div_quot;

   logic [ADDR_W-1:0]    prod_full;
   logic [ADDR_W:0]      offs_full;
   logic                 in_win_c;
   logic [QUOT_BITS-1:0] quot_c;
   logic [NODE_BITS-1:0] node_sat;
   logic                 is_local;
   logic [3:0]           xfer_c;

   logic [2:0]           outcome_c;
   logic [NODE_BITS-1:0] node_c;
   logic [3:0]           xfer_out;
   logic [ADDR_W-1:0]    wdata_c;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wbase_ff      <= '0;
         wsize_ff      <= '0;
         local_node_ff <= '0;
         node_count_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_payload.index)
            CSR_WINDOW_BASE: wbase_ff      <= csr_payload.data;
            CSR_WINDOW_SIZE: wsize_ff      <= csr_payload.data;
            CSR_LOCAL_NODE:  local_node_ff <= csr_payload.data[NODE_BITS-1:0];
            CSR_NODE_COUNT:  node_count_ff <= csr_payload.data[NODE_BITS-1:0];
         endcase
      end
   end

   // 64 x 4 product, low 64 bits kept
   assign prod_full = req_ff.index_value * {{(ADDR_W-4){1'b0}}, req_ff.scale_factor};
   assign offs_full = {1'b0, ea_ff} - {1'b0, wbase_ff};
   assign in_win_c  = (wsize_ff != '0) && !below_ff && (offset_ff < wsize_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_payload;
      end
      if (cmd.add_stage1) begin
         sum_ff  <= ADDR_W'(req_ff.displacement)
                  + (req_ff.base_present ? req_ff.base_value : '0);
         prod_ff <= req_ff.index_present ? prod_full : '0;
      end
      if (cmd.add_stage2) begin
         ea_ff <= sum_ff + prod_ff;
      end
      if (cmd.offset_calc) begin
         offset_ff <= offs_full[ADDR_W-1:0];
         below_ff  <= offs_full[ADDR_W];
      end
      if (cmd.range_check) begin
         in_win_ff   <= in_win_c;
         routable_ff <= in_win_c && share_ok_ff;
      end
   end

   // share = window_size / node_count, recomputed after a CSR change
   always_ff @(posedge clock) begin
      if (reset) begin
         share_ok_ff <= 1'b0;
      end else if (cmd.share_capture) begin
         share_ok_ff <= (node_count_ff != '0) && (div_quot != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.share_capture) begin
         share_ff <= div_quot;
      end
   end

   // Owner quotient is below 2^QUOT_BITS, so the high offset bits preload the remainder
   assign div_start    = cmd.div_share || cmd.div_node;
   assign div_rem_init = cmd.div_node ? (offset_ff >> QUOT_BITS) : '0;
   assign div_dividend = cmd.div_node ? (offset_ff << (ADDR_W - QUOT_BITS)) : wsize_ff;
   assign div_divisor  = cmd.div_node ? share_ff : ADDR_W'(node_count_ff);
   assign div_steps    = cmd.div_node ? NODE_STEPS : SHARE_STEPS;

   pnr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // node selection and outcome
   assign quot_c   = div_quot[QUOT_BITS-1:0];
   assign node_sat = (quot_c >= {1'b0, node_count_ff})
                   ? node_count_ff - NODE_BITS'(1) : quot_c[NODE_BITS-1:0];
   assign is_local = node_sat == local_node_ff;
   assign xfer_c   = (req_ff.access_bytes > 5'(XFER_CAP)) ? XFER_CAP
                                                          : req_ff.access_bytes[3:0];

   always_comb begin
      outcome_c     = OUT_RANGE;
      node_c        = '0;
      xfer_out      = '0;
      wdata_c       = '0;
      local_cnt_in  = local_cnt_ff;
      rload_cnt_in  = rload_cnt_ff;
      rstore_cnt_in = rstore_cnt_ff;
      priority if (routable_ff) begin
         node_c = node_sat;
         if (is_local) begin
            outcome_c    = OUT_LOCAL;
            local_cnt_in = local_cnt_ff + ADDR_W'(1);
         end else begin
            xfer_out = xfer_c;
            if (req_ff.cmd) begin
               outcome_c     = OUT_REMOTE_STORE;
               wdata_c       = req_ff.store_value;
               rstore_cnt_in = rstore_cnt_ff + ADDR_W'(1);
            end else begin
               outcome_c    = OUT_REMOTE_LOAD;
               rload_cnt_in = rload_cnt_ff + ADDR_W'(1);
            end
         end
      end else if (in_win_ff) begin
         outcome_c = OUT_UNROUTABLE;
      end else begin
         outcome_c = OUT_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_cnt_ff  <= '0;
         rload_cnt_ff  <= '0;
         rstore_cnt_ff <= '0;
      end else if (cmd.finish) begin
         local_cnt_ff  <= local_cnt_in;
         rload_cnt_ff  <= rload_cnt_in;
         rstore_cnt_ff <= rstore_cnt_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.outcome            <= outcome_c;
         rsp_ff.target_node        <= node_c;
         rsp_ff.effective_address  <= ea_ff;
         rsp_ff.transfer_bytes     <= xfer_out;
         rsp_ff.write_data         <= wdata_c;
         rsp_ff.local_total        <= local_cnt_in;
         rsp_ff.remote_load_total  <= rload_cnt_in;
         rsp_ff.remote_store_total <= rstore_cnt_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.routable  = in_win_c && share_ok_ff;
   assign sts.div_busy  = div_busy;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.cfg_touch = csr_valid && ((csr_payload.index == CSR_WINDOW_SIZE)
                                     || (csr_payload.index == CSR_NODE_COUNT));

endmodule

FILE: rtl/pgas_address_node_router.sv
// Sequence: load, two address add states, offset, range check, then the response load;
//   a routed request also runs the shared divider (17 one-bit steps find the owning node).
// A new request is taken only after the previous one has moved into the response register.
// A write to window_size or node_count recomputes the node share on the same divider
//   before the next request is taken.
// Reset: synchronous, clears CSRs, event counters, sequencer and response valid.
`timescale 1ns / 1ps
module pgas_address_node_router (
   input  logic      clock,
   input  logic      reset,
   pnr_req_if.sink   req_chan,
   pnr_rsp_if.source rsp_chan,
   pnr_csr_if.sink   csr_chan
);
   import pnr_pkg::*;

   pnr_cmd_type cmd;
   pnr_sts_type sts;
   logic        req_ready;
   logic        rsp_valid;
   pnr_rsp_type rsp_payload;

   // CSR writes are always accepted and land at the next clock edge
   assign csr_chan.ready = 1'b1;

   // Sequencer: share recompute, address add stages, window check, divider runs, response load.
   // Takes a new request only once the previous one has moved into the response
   // register, so a waiting response holds back only the next request's response load.
   pnr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: CSRs, effective address, window offset, share/owner division,
   // node clamp, event counters and the response register.
   pnr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_chan.payload),
      .csr_valid   (csr_chan.valid),
      .csr_payload (csr_chan.payload),
      .rsp_ready   (rsp_chan.ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   assign req_chan.ready   = req_ready;
   assign rsp_chan.valid   = rsp_valid;
   assign rsp_chan.payload = rsp_payload;

endmodule

FILE: rtl/pnr_checker.sv
// Port-level checker for the address node router, bound to the top level
`timescale 1ns / 1ps
`include "pgas_address_node_router_macros.svh"
module pnr_checker (
   input logic       clock,
   input logic       reset,
   pnr_rsp_if.source rsp_chan
);
   import pnr_pkg::*;

   logic not_remote;
   logic not_store;

   assign not_remote = (rsp_chan.payload.outcome != OUT_REMOTE_LOAD)
                    && (rsp_chan.payload.outcome != OUT_REMOTE_STORE);
   assign not_store  = rsp_chan.payload.outcome != OUT_REMOTE_STORE;

   `PNR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid)
   `PNR_ASSERT_SAME(a_xfer_remote_only, clock, reset, rsp_chan.valid && not_remote, rsp_chan.payload.transfer_bytes == '0)
   `PNR_ASSERT_SAME(a_wdata_store_only, clock, reset, rsp_chan.valid && not_store, rsp_chan.payload.write_data == '0)
   `PNR_ASSERT_SAME(a_node_unrouted_zero, clock, reset, rsp_chan.valid && ((rsp_chan.payload.outcome == OUT_RANGE) || (rsp_chan.payload.outcome == OUT_UNROUTABLE)), rsp_chan.payload.target_node == '0)

endmodule

bind pgas_address_node_router pnr_checker u_pnr_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_chan (rsp_chan)
);
